/* hw/rtl/nifd_pkg.sv */
`timescale 1ns / 1ps

package nifd_pkg;

  // Register indexes on the configuration port.
  localparam logic [7:0] REG_PREAMBLE_LENGTH     = 8'd0;
  localparam logic [7:0] REG_PREAMBLE_TOLERANCE  = 8'd1;
  localparam logic [7:0] REG_SPACE_LENGTH        = 8'd2;
  localparam logic [7:0] REG_REPEAT_SPACE_LENGTH = 8'd3;
  localparam logic [7:0] REG_SPACE_TOLERANCE     = 8'd4;
  localparam logic [7:0] REG_BIT_PULSE_LENGTH    = 8'd5;
  localparam logic [7:0] REG_BIT_PULSE_TOLERANCE = 8'd6;
  localparam logic [7:0] REG_IDLE_TIMEOUT        = 8'd7;

  // Error codes reported with each result item.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_PREAMBLE = 3'd1;
  localparam logic [2:0] ERR_SPACE    = 3'd2;
  localparam logic [2:0] ERR_BIT      = 3'd3;
  localparam logic [2:0] ERR_INVERSE  = 3'd4;

  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0] error_code;
    logic       frame_valid;
    logic [7:0] address;
    logic [7:0] command;
  } out_item_t;

  typedef struct packed {
    logic [15:0] preamble_length;
    logic [15:0] preamble_tolerance;
    logic [15:0] space_length;
    logic [15:0] repeat_space_length;
    logic [15:0] space_tolerance;
    logic [15:0] bit_pulse_length;
    logic [15:0] bit_pulse_tolerance;
    logic [23:0] idle_timeout;
  } cfg_t;

  // Magnitude of a wrapped 32-bit difference read as a signed value.
  function automatic logic [31:0] mag32(input logic [31:0] x);
    mag32 = x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

/* hw/rtl/nifd_cfg_regs.sv */
`timescale 1ns / 1ps

module nifd_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [7:0]        wr_index,
  input  logic [23:0]       wr_data,
  output nifd_pkg::cfg_t    cfg
);

  nifd_pkg::cfg_t cfg_r;
  nifd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        nifd_pkg::REG_PREAMBLE_LENGTH:     cfg_nxt.preamble_length     = wr_data[15:0];
        nifd_pkg::REG_PREAMBLE_TOLERANCE:  cfg_nxt.preamble_tolerance  = wr_data[15:0];
        nifd_pkg::REG_SPACE_LENGTH:        cfg_nxt.space_length        = wr_data[15:0];
        nifd_pkg::REG_REPEAT_SPACE_LENGTH: cfg_nxt.repeat_space_length = wr_data[15:0];
        nifd_pkg::REG_SPACE_TOLERANCE:     cfg_nxt.space_tolerance     = wr_data[15:0];
        nifd_pkg::REG_BIT_PULSE_LENGTH:    cfg_nxt.bit_pulse_length    = wr_data[15:0];
        nifd_pkg::REG_BIT_PULSE_TOLERANCE: cfg_nxt.bit_pulse_tolerance = wr_data[15:0];
        nifd_pkg::REG_IDLE_TIMEOUT:        cfg_nxt.idle_timeout        = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_length     <= 16'd9000;
      cfg_r.preamble_tolerance  <= 16'd1000;
      cfg_r.space_length        <= 16'd4500;
      cfg_r.repeat_space_length <= 16'd2250;
      cfg_r.space_tolerance     <= 16'd500;
      cfg_r.bit_pulse_length    <= 16'd560;
      cfg_r.bit_pulse_tolerance <= 16'd200;
      cfg_r.idle_timeout        <= 24'd110000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/nifd_parser.sv */
`timescale 1ns / 1ps

module nifd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  nifd_pkg::in_item_t   item,
  input  nifd_pkg::cfg_t       cfg,
  output nifd_pkg::out_item_t  result
);

  localparam logic [3:0] ST_WAIT  = 4'd0;
  localparam logic [3:0] ST_PRE   = 4'd1;
  localparam logic [3:0] ST_SPACE = 4'd2;
  localparam logic [3:0] ST_START = 4'd3;
  localparam logic [3:0] ST_BYTE0 = 4'd4;
  localparam logic [3:0] ST_BYTE1 = 4'd5;
  localparam logic [3:0] ST_BYTE2 = 4'd6;
  localparam logic [3:0] ST_BYTE3 = 4'd7;
  localparam logic [3:0] ST_END   = 4'd8;

  logic [3:0]  state_r,   state_nxt;
  logic [31:0] last_r,    last_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic        phase_r,   phase_nxt;
  logic [7:0]  shift_r,   shift_nxt;
  logic [7:0]  bytes_r   [4];
  logic [7:0]  bytes_nxt [4];

  logic [31:0] delta;
  logic        pre_bad;
  logic        space_ok;
  logic        repeat_ok;
  logic        pulse_bad;
  logic        idle_over;
  logic        bit_one;
  logic [7:0]  shift_set;
  logic        inverse_ok;

  always_comb begin
    delta     = item.event_time - last_r;
    pre_bad   = nifd_pkg::mag32(delta - {16'd0, cfg.preamble_length})
                > {16'd0, cfg.preamble_tolerance};
    space_ok  = nifd_pkg::mag32(delta - {16'd0, cfg.space_length})
                <= {16'd0, cfg.space_tolerance};
    repeat_ok = nifd_pkg::mag32(delta - {16'd0, cfg.repeat_space_length})
                <= {16'd0, cfg.space_tolerance};
    pulse_bad = nifd_pkg::mag32(delta - {16'd0, cfg.bit_pulse_length})
                > {16'd0, cfg.bit_pulse_tolerance};
    idle_over = nifd_pkg::mag32(delta) > {8'd0, cfg.idle_timeout};
    // A long space before the mark means a one; a wrapped negative interval reads as zero.
    bit_one   = !delta[31] && (delta > {15'd0, cfg.bit_pulse_length, 1'b0});
    shift_set = shift_r | (8'(bit_one) << bit_idx_r);
    inverse_ok = ((bytes_r[0] ^ bytes_r[1]) == 8'hFF) &&
                 ((bytes_r[2] ^ bytes_r[3]) == 8'hFF);
  end

  always_comb begin
    state_nxt   = state_r;
    last_nxt    = last_r;
    bit_idx_nxt = bit_idx_r;
    phase_nxt   = phase_r;
    shift_nxt   = shift_r;
    for (int i = 0; i < 4; i++) begin
      bytes_nxt[i] = bytes_r[i];
    end
    result = '0;

    if (go) begin
      if (item.func == nifd_pkg::FUNC_POLL) begin
        if (idle_over) begin
          state_nxt = ST_WAIT;
          for (int i = 0; i < 4; i++) begin
            bytes_nxt[i] = 8'd0;
          end
        end
      end else begin
        case (state_r)
          ST_WAIT: begin
            last_nxt  = item.event_time;
            state_nxt = ST_PRE;
          end
          ST_PRE: begin
            if (pre_bad) begin
              result.error_code = nifd_pkg::ERR_PREAMBLE;
            end
            last_nxt  = item.event_time;
            state_nxt = ST_SPACE;
          end
          ST_SPACE: begin
            if (space_ok) begin
              state_nxt = ST_START;
            end else if (repeat_ok) begin
              state_nxt = ST_END;
            end else begin
              result.error_code = nifd_pkg::ERR_SPACE;
              state_nxt = ST_START;
            end
            last_nxt = item.event_time;
          end
          ST_START: begin
            phase_nxt   = 1'b0;
            bit_idx_nxt = 3'd0;
            shift_nxt   = 8'd0;
            last_nxt    = item.event_time;
            state_nxt   = ST_BYTE0;
          end
          ST_BYTE0, ST_BYTE1, ST_BYTE2, ST_BYTE3: begin
            if (!phase_r) begin
              phase_nxt = 1'b1;
              if (bit_idx_r == 3'd7) begin
                bytes_nxt[state_r[1:0]] = shift_set;
                bit_idx_nxt = 3'd0;
                shift_nxt   = 8'd0;
                state_nxt   = state_r + 4'd1;
              end else begin
                shift_nxt   = shift_set;
                bit_idx_nxt = bit_idx_r + 3'd1;
              end
            end else begin
              phase_nxt = 1'b0;
              if (pulse_bad) begin
                result.error_code = nifd_pkg::ERR_BIT;
              end
            end
            last_nxt = item.event_time;
          end
          ST_END: begin
            if (inverse_ok) begin
              result.frame_valid = 1'b1;
              result.address     = bytes_r[0];
              result.command     = bytes_r[2];
              state_nxt          = ST_WAIT;
            end else begin
              result.error_code = nifd_pkg::ERR_INVERSE;
            end
          end
          default: begin
            state_nxt = ST_WAIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_WAIT;
      last_r    <= 32'd0;
      bit_idx_r <= 3'd0;
      phase_r   <= 1'b0;
      shift_r   <= 8'd0;
      for (int i = 0; i < 4; i++) begin
        bytes_r[i] <= 8'd0;
      end
    end else begin
      state_r   <= state_nxt;
      last_r    <= last_nxt;
      bit_idx_r <= bit_idx_nxt;
      phase_r   <= phase_nxt;
      shift_r   <= shift_nxt;
      for (int i = 0; i < 4; i++) begin
        bytes_r[i] <= bytes_nxt[i];
      end
    end
  end

  // A reported frame never carries an error, and it sends the parser back to wait.
  a_valid_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    go && result.frame_valid |-> result.error_code == nifd_pkg::ERR_NONE)
    else $error("frame reported together with an error");

  a_valid_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
    go && result.frame_valid |=> state_r == ST_WAIT)
    else $error("parser did not return to wait after a frame");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.func == nifd_pkg::FUNC_EDGE && state_r == ST_START
    |=> bit_idx_r == 3'd0 && !phase_r && shift_r == 8'd0 && state_r == ST_BYTE0)
    else $error("data start did not clear the bit counters");

  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r <= ST_END)
    else $error("parser reached an unused state code");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(state_r) && $stable(last_r) && $stable(shift_r))
    else $error("parser state moved without an item");

endmodule

/* hw/rtl/nec_ir_frame_decoder_top.sv */
`timescale 1ns / 1ps

// NEC infrared frame decoder.
// Input channel (in_valid/in_ready/in_data): one item per signal edge or
// timeout poll, each with a 32-bit microsecond timestamp. Every item yields
// exactly one result item on the output channel (out_valid/out_ready/out_data)
// carrying an error code, a frame-valid flag and the address and command bytes.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// eight timing registers; cfg_ready is always high and unknown indexes are
// ignored. Write registers only while no item is in flight.
// An accepted item is held in an input register, parsed from there, and
// its result lands in the output register that drives out_valid. The
// parse is one compare-and-update pass per item and the two registers
// overlap, so one item per cycle is sustained while out_ready stays high.
// When out_ready is low the result waits in the output register; the input
// register still takes one more item, and then in_ready drops until the
// output slot drains.
// A synchronous reset (rst_n low) empties both registers, puts the parser in
// its wait state with cleared bytes and timestamp, and restores the register
// defaults.

module nec_ir_frame_decoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nifd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nifd_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [23:0]          cfg_data
);

  nifd_pkg::cfg_t      cfg;
  nifd_pkg::in_item_t  hold_item_r;
  nifd_pkg::out_item_t out_data_r;
  nifd_pkg::out_item_t result;
  logic                hold_valid_r, hold_valid_nxt;
  logic                out_valid_r,  out_valid_nxt;
  logic                advance;
  logic                in_acc;

  assign cfg_ready = 1'b1;

  nifd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance  = hold_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !hold_valid_r || advance;
  assign in_acc   = in_valid && in_ready;

  nifd_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (advance),
    .item   (hold_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_acc) begin
      hold_valid_nxt = 1'b1;
    end else if (advance) begin
      hold_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* verif/nec_ir_frame_decoder_top_tb.sv */
`timescale 1ns / 1ps

module nec_ir_frame_decoder_top_tb;

  localparam int DIR_ROWS    = 23;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 140;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [7:0] REG_COUNT = 8'd8;

  typedef enum logic [3:0] {
    PS_WAIT  = 4'd0,
    PS_LEAD  = 4'd1,
    PS_SPACE = 4'd2,
    PS_START = 4'd3,
    PS_BYTE0 = 4'd4,
    PS_BYTE1 = 4'd5,
    PS_BYTE2 = 4'd6,
    PS_BYTE3 = 4'd7,
    PS_END   = 4'd8
  } ir_state_t;

  typedef struct packed {
    logic                func;
    logic [31:0]         stamp;
    logic                pinned;
    nifd_pkg::out_item_t res;
  } dir_row_t;

  localparam nifd_pkg::out_item_t QUIET   = '0;
  localparam nifd_pkg::out_item_t BAD_INV = '{nifd_pkg::ERR_INVERSE, 1'b0, 8'h00, 8'h00};

  // Register defaults hold throughout the table; later rows carry on from the
  // parser state that the earlier rows leave behind.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{nifd_pkg::FUNC_POLL, 32'h0000_0000, 1'b1, QUIET},
    '{nifd_pkg::FUNC_POLL, 32'hFFFF_FFFF, 1'b1, QUIET},
    '{nifd_pkg::FUNC_POLL, 32'h8000_0000, 1'b1, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'hFFFF_FFFF, 1'b1, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'h0000_2327, 1'b1, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'h0000_2BF1, 1'b1, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'h0000_2E21, 1'b1, BAD_INV},
    '{nifd_pkg::FUNC_EDGE, 32'hFFFF_FFFF, 1'b1, BAD_INV},
    '{nifd_pkg::FUNC_POLL, 32'h0001_D9A1, 1'b1, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'h0000_0000, 1'b1, BAD_INV},
    '{nifd_pkg::FUNC_POLL, 32'h0001_D9A2, 1'b1, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'h0003_0D40, 1'b1, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'h0003_3451, 1'b1,
      '{nifd_pkg::ERR_PREAMBLE, 1'b0, 8'h00, 8'h00}},
    '{nifd_pkg::FUNC_EDGE, 32'h0003_47DA, 1'b1,
      '{nifd_pkg::ERR_SPACE, 1'b0, 8'h00, 8'h00}},
    '{nifd_pkg::FUNC_EDGE, 32'h0003_4A0A, 1'b1, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'h8003_4A0A, 1'b1, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'h8003_4D03, 1'b1,
      '{nifd_pkg::ERR_BIT, 1'b0, 8'h00, 8'h00}},
    '{nifd_pkg::FUNC_EDGE, 32'h8003_5164, 1'b0, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'h8003_52CC, 1'b0, QUIET},
    '{nifd_pkg::FUNC_POLL, 32'h8003_52D1, 1'b0, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'h8003_572C, 1'b0, QUIET},
    '{nifd_pkg::FUNC_EDGE, 32'h8003_572C, 1'b0, QUIET},
    '{nifd_pkg::FUNC_POLL, 32'hFFFF_FFFF, 1'b0, QUIET}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  nifd_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  nifd_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [7:0]          cfg_index;
  logic [23:0]         cfg_data;

  // Decoder state mirrored by the predictor.
  nifd_pkg::cfg_t      regs_model;
  ir_state_t           ps;
  logic [31:0]         last_edge;
  logic [2:0]          bit_idx;
  logic                bit_ph;
  logic [7:0]          shreg;
  logic [7:0]          fb [4];

  nifd_pkg::out_item_t decode_q [$];
  logic                pin_on;
  nifd_pkg::out_item_t pin_res;
  int                  mismatches;
  int                  cycles;
  int                  items_sent;
  int                  idle_pct;
  int                  stall_pct;
  int                  hold_reqs;
  int                  hold_seen;
  int                  hold_left;
  int                  fr_edges;
  int                  fr_limit;
  logic [31:0]         now;

  nec_ir_frame_decoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] wrap_mag(logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic nifd_pkg::out_item_t predict_ir(nifd_pkg::in_item_t it);
    nifd_pkg::out_item_t r;
    logic [31:0]         dt;
    logic [31:0]         bp;
    logic [31:0]         stol;
    ir_state_t           old;
    r = '0;
    dt = it.event_time - last_edge;
    bp = {16'h0, regs_model.bit_pulse_length};
    stol = {16'h0, regs_model.space_tolerance};
    old = ps;
    if (it.func == nifd_pkg::FUNC_POLL) begin
      if (wrap_mag(dt) > {8'h0, regs_model.idle_timeout}) begin
        ps = PS_WAIT;
        fb = '{default: 8'h00};
      end
    end else begin
      case (ps)
        PS_WAIT: ps = PS_LEAD;
        PS_LEAD: begin
          if (wrap_mag(dt - {16'h0, regs_model.preamble_length}) >
              {16'h0, regs_model.preamble_tolerance})
            r.error_code = nifd_pkg::ERR_PREAMBLE;
          ps = PS_SPACE;
        end
        PS_SPACE: begin
          if (wrap_mag(dt - {16'h0, regs_model.space_length}) <= stol) begin
            ps = PS_START;
          end else if (wrap_mag(dt - {16'h0, regs_model.repeat_space_length}) <= stol) begin
            ps = PS_END;
          end else begin
            r.error_code = nifd_pkg::ERR_SPACE;
            ps = PS_START;
          end
        end
        PS_START: begin
          bit_ph = 1'b0;
          bit_idx = 3'd0;
          shreg = 8'h00;
          ps = PS_BYTE0;
        end
        PS_BYTE0, PS_BYTE1, PS_BYTE2, PS_BYTE3: begin
          if (!bit_ph) begin
            bit_ph = 1'b1;
            // A backward interval never reads as a one.
            if (!dt[31] && dt > (bp << 1))
              shreg[bit_idx] = 1'b1;
            if (bit_idx == 3'd7) begin
              fb[2'(ps - PS_BYTE0)] = shreg;
              bit_idx = 3'd0;
              shreg = 8'h00;
              ps = ir_state_t'(ps + 4'd1);
            end else begin
              bit_idx = bit_idx + 3'd1;
            end
          end else begin
            bit_ph = 1'b0;
            if (wrap_mag(dt - bp) > {16'h0, regs_model.bit_pulse_tolerance})
              r.error_code = nifd_pkg::ERR_BIT;
          end
        end
        PS_END: begin
          if ((fb[0] ^ fb[1]) == 8'hFF && (fb[2] ^ fb[3]) == 8'hFF) begin
            r.frame_valid = 1'b1;
            r.address = fb[0];
            r.command = fb[2];
            ps = PS_WAIT;
          end else begin
            r.error_code = nifd_pkg::ERR_INVERSE;
          end
        end
        default: ps = PS_WAIT;
      endcase
      // The end state leaves the edge timestamp alone.
      if (old <= PS_BYTE3)
        last_edge = it.event_time;
    end
    return r;
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    nifd_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (decode_q.size() == 0) begin
          $error("result item with nothing expected: %p", out_data);
          mismatches++;
        end else begin
          want = decode_q.pop_front();
          check_field("error_code", want.error_code, out_data.error_code);
          check_field("frame_valid", want.frame_valid, out_data.frame_valid);
          check_field("address", want.address, out_data.address);
          check_field("command", want.command, out_data.command);
        end
      end
      if (in_valid && in_ready) begin
        want = predict_ir(in_data);
        if (pin_on)
          want = pin_res;
        decode_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = LONG_HOLD;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Entered just after a falling edge; returns just after the falling edge
  // that follows acceptance.
  task automatic push_ir(logic f, logic [31:0] t);
    if ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_data = '{func: f, event_time: t};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [23:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      nifd_pkg::REG_PREAMBLE_LENGTH:     regs_model.preamble_length = val[15:0];
      nifd_pkg::REG_PREAMBLE_TOLERANCE:  regs_model.preamble_tolerance = val[15:0];
      nifd_pkg::REG_SPACE_LENGTH:        regs_model.space_length = val[15:0];
      nifd_pkg::REG_REPEAT_SPACE_LENGTH: regs_model.repeat_space_length = val[15:0];
      nifd_pkg::REG_SPACE_TOLERANCE:     regs_model.space_tolerance = val[15:0];
      nifd_pkg::REG_BIT_PULSE_LENGTH:    regs_model.bit_pulse_length = val[15:0];
      nifd_pkg::REG_BIT_PULSE_TOLERANCE: regs_model.bit_pulse_tolerance = val[15:0];
      nifd_pkg::REG_IDLE_TIMEOUT:        regs_model.idle_timeout = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (decode_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_regs(int setting);
    nifd_pkg::cfg_t nv;
    logic [7:0]     hi;
    hi = 8'h00;
    case (setting)
      0: nv = '{16'd9000, 16'd1000, 16'd4500, 16'd2250, 16'd500, 16'd560, 16'd200,
                24'd110000};
      2: nv = '0;
      3: nv = '1;
      4: begin
        nv = {$urandom, $urandom, $urandom, $urandom, 8'($urandom)};
        hi = 8'($urandom);
      end
      default: begin
        nv.preamble_length = 16'($urandom_range(20000, 2000));
        nv.preamble_tolerance = 16'($urandom_range(3000));
        nv.space_length = 16'($urandom_range(9000, 1000));
        nv.repeat_space_length = 16'($urandom_range(9000, 500));
        nv.space_tolerance = 16'($urandom_range(1000));
        nv.bit_pulse_length = 16'($urandom_range(1500, 100));
        nv.bit_pulse_tolerance = 16'($urandom_range(400));
        nv.idle_timeout = 24'($urandom_range(24'hFF_FFFF, 50000));
        hi = 8'($urandom);
      end
    endcase
    // Upper data bits of the 16-bit registers carry junk in some settings.
    write_reg(nifd_pkg::REG_PREAMBLE_LENGTH, {hi, nv.preamble_length});
    write_reg(nifd_pkg::REG_PREAMBLE_TOLERANCE, {hi, nv.preamble_tolerance});
    write_reg(nifd_pkg::REG_SPACE_LENGTH, {hi, nv.space_length});
    write_reg(nifd_pkg::REG_REPEAT_SPACE_LENGTH, {hi, nv.repeat_space_length});
    write_reg(nifd_pkg::REG_SPACE_TOLERANCE, {hi, nv.space_tolerance});
    write_reg(nifd_pkg::REG_BIT_PULSE_LENGTH, {hi, nv.bit_pulse_length});
    write_reg(nifd_pkg::REG_BIT_PULSE_TOLERANCE, {hi, nv.bit_pulse_tolerance});
    write_reg(nifd_pkg::REG_IDLE_TIMEOUT, nv.idle_timeout);
    write_reg(REG_COUNT + 8'($urandom_range(247)), 24'($urandom));
    cfg_valid = 1'b0;
  endtask

  // Nominal length with jitter inside the tolerance, now and then far off.
  function automatic logic [31:0] near(logic [31:0] len, logic [31:0] tol);
    logic [31:0] lo;
    lo = (tol > len) ? len : tol;
    if ($urandom_range(99) < 4)
      return $urandom_range(200000);
    return len - lo + $urandom_range(lo + tol);
  endfunction

  task automatic edge_after(logic [31:0] dt);
    if (fr_edges >= fr_limit)
      return;
    fr_edges++;
    if ($urandom_range(99) < 3)
      push_ir(nifd_pkg::FUNC_POLL, now + $urandom_range(1000));
    now = now + dt;
    push_ir(nifd_pkg::FUNC_EDGE, now);
  endtask

  task automatic send_frame(bit rpt, int limit);
    logic [7:0]  a;
    logic [7:0]  c;
    logic [7:0]  ai;
    logic [7:0]  ci;
    logic [31:0] word;
    logic [31:0] bp;
    logic [31:0] btol;
    logic [31:0] stol;
    a = 8'($urandom);
    c = 8'($urandom);
    ai = ~a;
    ci = ~c;
    if ($urandom_range(9) == 0)
      ai = 8'($urandom);
    if ($urandom_range(9) == 0)
      ci = 8'($urandom);
    word = {ci, c, ai, a};
    bp = {16'h0, regs_model.bit_pulse_length};
    btol = {16'h0, regs_model.bit_pulse_tolerance};
    stol = {16'h0, regs_model.space_tolerance};
    fr_edges = 0;
    fr_limit = limit;
    // Time the parser out first if it is not waiting, and now and then when it is; a repeat code
    // straight after a good frame keeps the stored bytes.
    if (ps != PS_WAIT || $urandom_range(9) == 0) begin
      now = last_edge + {8'h0, regs_model.idle_timeout} + 32'd1 + $urandom_range(5000);
      push_ir(nifd_pkg::FUNC_POLL, now);
    end
    edge_after($urandom_range(300000));
    edge_after(near({16'h0, regs_model.preamble_length},
                    {16'h0, regs_model.preamble_tolerance}));
    edge_after(rpt ? near({16'h0, regs_model.repeat_space_length}, stol)
                   : near({16'h0, regs_model.space_length}, stol));
    if (!rpt) begin
      edge_after(near(bp, btol));
      for (int k = 0; k < 32; k++) begin
        edge_after(word[k] ? (bp << 1) + 32'd1 + $urandom_range(bp + 50)
                           : $urandom_range(bp << 1));
        edge_after(near(bp, btol));
      end
    end
    edge_after(near(bp, btol));
  endtask

  initial begin
    int goal;
    int sel;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pin_on = 1'b0;
    pin_res = '0;
    mismatches = 0;
    cycles = 0;
    items_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_reqs = 0;
    hold_seen = 0;
    hold_left = 0;
    now = '0;
    regs_model = '{16'd9000, 16'd1000, 16'd4500, 16'd2250, 16'd500, 16'd560, 16'd200,
                   24'd110000};
    ps = PS_WAIT;
    last_edge = '0;
    bit_idx = '0;
    bit_ph = 1'b0;
    shreg = '0;
    fb = '{default: 8'h00};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      pin_on = DIR_TABLE[i].pinned;
      pin_res = DIR_TABLE[i].res;
      push_ir(DIR_TABLE[i].func, DIR_TABLE[i].stamp);
    end
    pin_on = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      program_regs(p);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      // Back up the result side while items keep coming.
      if (p == 0)
        hold_reqs++;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        sel = $urandom_range(99);
        if (sel < 65)
          send_frame(1'b0, 1000);
        else if (sel < 80)
          send_frame(1'b1, 1000);
        else if (sel < 90)
          send_frame(1'($urandom_range(1)), $urandom_range(60, 1));
        else
          repeat ($urandom_range(20, 5)) push_ir(1'($urandom_range(1)), $urandom);
      end
    end

    in_valid = 1'b0;
    while (decode_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/nifd_pkg.sv
hw/rtl/nifd_cfg_regs.sv
hw/rtl/nifd_parser.sv
hw/rtl/nec_ir_frame_decoder_top.sv
verif/nec_ir_frame_decoder_top_tb.sv
